// ----- hdl/pendulum_pd_pi_motor_controller_unit_defines.svh -----
// Assertion macros for the pendulum controller checker.
`ifndef PENDULUM_PD_PI_MOTOR_CONTROLLER_UNIT_DEFINES_SVH
`define PENDULUM_PD_PI_MOTOR_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define PDPI_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define PDPI_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pdpi_pkg.sv -----
// Shared types, constants and helpers of the pendulum PD/PI controller.
`timescale 1ns / 1ps
package pdpi_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 16;
	localparam int DUTY_W     = 13;
	localparam int ENC_W      = 16;
	localparam int TGT_W      = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam int ERR_W   = SAMPLE_W + 1;
	localparam int DERR_W  = ERR_W + 1;
	localparam int FILT_W  = ENC_W + FRAC_BITS;
	localparam int INTEG_W = 10 + FRAC_BITS;
	localparam int ISUM_W  = FILT_W + 3;
	localparam int MUL_A_W = FILT_W + 1;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int PD_W    = GAIN_W + DERR_W + 2 - FRAC_BITS;
	localparam int CMD_W   = ACC_W - 2 * FRAC_BITS + 1;

	localparam int FILT_OLD   = 205;
	localparam int FILT_NEW_Q = 51 << FRAC_BITS;
	localparam int INTEG_LIM  = 500 << FRAC_BITS;
	localparam int FILT_MAX   = (1 << (FILT_W - 1)) - 1;
	localparam int FILT_MIN   = -(1 << (FILT_W - 1));

	localparam logic [GAIN_W-1:0]   RST_ANGLE_KP    = 16'd3840;
	localparam logic [GAIN_W-1:0]   RST_ANGLE_KD    = 16'd20480;
	localparam logic [GAIN_W-1:0]   RST_SPEED_KP    = 16'd33280;
	localparam logic [GAIN_W-1:0]   RST_SPEED_KI    = 16'd384;
	localparam logic [SAMPLE_W-1:0] RST_SETPOINT    = 12'd3270;
	localparam logic [DUTY_W-1:0]   RST_DUTY_LIMIT  = 13'd900;
	localparam logic [SAMPLE_W-1:0] RST_WINDOW_LOW  = 12'd2900;
	localparam logic [SAMPLE_W-1:0] RST_WINDOW_HIGH = 12'd3600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_KP,
		REG_ANGLE_KD,
		REG_SPEED_KP,
		REG_SPEED_KI,
		REG_SETPOINT,
		REG_DUTY_LIMIT,
		REG_WINDOW_LOW,
		REG_WINDOW_HIGH
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_KP_ERR,
		MS_KD_DERR,
		MS_FILT_OLD,
		MS_ENC_NEW,
		MS_FILT_SKP,
		MS_INTEG_SKI
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_KP,
		ST_MUL_KD,
		ST_MUL_FO,
		ST_MUL_FN,
		ST_FSUM,
		ST_FSAT,
		ST_MUL_SKP,
		ST_MUL_SKI,
		ST_PISUM,
		ST_CMD,
		ST_OUT
	} step_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     take;
		logic     prev_ld;
		logic     pd_ld;
		logic     filt_ld;
		logic     integ_ld;
		logic     cmd_ld;
		logic     out_ld;
	} ctrl_t;

	// Divide by 2^F, truncating toward zero.
	function automatic logic signed [ACC_W-1:0] trunc_shr_f(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] b;
		b = v[ACC_W-1] ? v + $signed(ACC_W'((1 << FRAC_BITS) - 1)) : v;
		return b >>> FRAC_BITS;
	endfunction

	// Divide by 2^(2F), truncating toward zero.
	function automatic logic signed [ACC_W-1:0] trunc_shr_2f(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] b;
		b = v[ACC_W-1] ? v + $signed(ACC_W'((1 << (2 * FRAC_BITS)) - 1)) : v;
		return b >>> (2 * FRAC_BITS);
	endfunction

endpackage

// ----- hdl/pdpi_ifs.sv -----
// Valid/ready channel interfaces for controller ticks and results.
`timescale 1ns / 1ps
interface pdpi_in_if;
	import pdpi_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [SAMPLE_W-1:0]        angle_sample;
	logic signed [ENC_W-1:0]    encoder_count;
	logic signed [TGT_W-1:0]    target_speed;
	modport source (output valid, angle_sample, encoder_count, target_speed, input ready);
	modport sink (input valid, angle_sample, encoder_count, target_speed, output ready);
endinterface

interface pdpi_out_if;
	import pdpi_pkg::*;
	logic               valid;
	logic               ready;
	logic [DUTY_W-1:0]  duty;
	logic               drive_negative;
	logic               cut_off;
	modport source (output valid, duty, drive_negative, cut_off, input ready);
	modport sink (input valid, duty, drive_negative, cut_off, output ready);
endinterface

// ----- hdl/pdpi_mac.sv -----
// Shared signed multiply-accumulate unit: registered product, then accumulator.
`timescale 1ns / 1ps
module pdpi_mac (
	input  logic                                 clk,
	input  logic signed [pdpi_pkg::MUL_A_W-1:0]  mul_a,
	input  logic signed [pdpi_pkg::MUL_B_W-1:0]  mul_b,
	input  pdpi_pkg::acc_op_t                    acc_op,
	output logic signed [pdpi_pkg::ACC_W-1:0]    acc
);
	import pdpi_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_s1);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			default:  acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ----- hdl/pdpi_seq.sv -----
// Step sequencer driving the shared multiply-accumulate and state loads.
`timescale 1ns / 1ps
module pdpi_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_busy,
	output logic            in_ready,
	output pdpi_pkg::ctrl_t ctrl
);
	import pdpi_pkg::*;

	step_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.take = 1'b1;
					state_d   = ST_MUL_KP;
				end
			end
			ST_MUL_KP: begin
				ctrl.mul_sel = MS_KP_ERR;
				state_d      = ST_MUL_KD;
			end
			ST_MUL_KD: begin
				ctrl.mul_sel = MS_KD_DERR;
				ctrl.acc_op  = ACC_LOAD;
				ctrl.prev_ld = 1'b1;
				state_d      = ST_MUL_FO;
			end
			ST_MUL_FO: begin
				ctrl.mul_sel = MS_FILT_OLD;
				ctrl.acc_op  = ACC_ADD;
				state_d      = ST_MUL_FN;
			end
			ST_MUL_FN: begin
				ctrl.mul_sel = MS_ENC_NEW;
				ctrl.acc_op  = ACC_LOAD;
				ctrl.pd_ld   = 1'b1;
				state_d      = ST_FSUM;
			end
			ST_FSUM: begin
				ctrl.acc_op = ACC_ADD;
				state_d     = ST_FSAT;
			end
			ST_FSAT: begin
				ctrl.filt_ld = 1'b1;
				state_d      = ST_MUL_SKP;
			end
			ST_MUL_SKP: begin
				ctrl.mul_sel  = MS_FILT_SKP;
				ctrl.integ_ld = 1'b1;
				state_d       = ST_MUL_SKI;
			end
			ST_MUL_SKI: begin
				ctrl.mul_sel = MS_INTEG_SKI;
				ctrl.acc_op  = ACC_LOAD;
				state_d      = ST_PISUM;
			end
			ST_PISUM: begin
				ctrl.acc_op = ACC_ADD;
				state_d     = ST_CMD;
			end
			ST_CMD: begin
				ctrl.cmd_ld = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					ctrl.out_ld = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/pendulum_pd_pi_motor_controller_unit.sv -----
// Top level of the cascaded PD angle / PI speed pendulum motor controller.
// One control tick is accepted when the block is idle. The result beat is loaded into the
// output register in the last step after acceptance, or later if the previous result has
// not been taken yet. The block then returns to idle before it accepts the next tick, so
// it takes a new tick only once it is through with the last one. The step sequence is set
// by the single 25x17-bit multiply-accumulate unit, which forms the six products of a tick
// one at a time, with filter and integral updates between them, then command and output steps.
// The finished result waits in its own register, so a new tick can be accepted
// while it is still pending. No clearing pass is needed after reset.
`timescale 1ns / 1ps
module pendulum_pd_pi_motor_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdpi_pkg::CFG_DATA_W-1:0]     cfg_data,
	pdpi_in_if.sink                             sample,
	pdpi_out_if.source                          result
);
	import pdpi_pkg::*;

	localparam logic signed [ACC_W-1:0]   FILT_MAX_A  = ACC_W'(FILT_MAX);
	localparam logic signed [ACC_W-1:0]   FILT_MIN_A  = ACC_W'(FILT_MIN);
	localparam logic signed [ISUM_W-1:0]  INTEG_MAX_S = ISUM_W'(INTEG_LIM);
	localparam logic signed [ISUM_W-1:0]  INTEG_MIN_S = ISUM_W'(-INTEG_LIM);

	logic [GAIN_W-1:0]   angle_kp_q, angle_kd_q, speed_kp_q, speed_ki_q;
	logic [SAMPLE_W-1:0] angle_setpoint_q, window_low_q, window_high_q;
	logic [DUTY_W-1:0]   duty_limit_q;

	logic signed [ERR_W-1:0]   err_q, prev_q;
	logic signed [ENC_W-1:0]   enc_q;
	logic signed [TGT_W-1:0]   tgt_q;
	logic                      cut_q;
	logic signed [FILT_W-1:0]  filt_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [PD_W-1:0]    pd_q;
	logic signed [CMD_W-1:0]   cmd_q;

	logic                out_valid_q;
	logic [DUTY_W-1:0]   duty_q;
	logic                neg_q;
	logic                cut_out_q;

	ctrl_t                      ctrl;
	logic                       in_ready;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]    acc;
	logic signed [DERR_W-1:0]   derr;
	logic signed [ERR_W-1:0]    err_new;
	logic signed [ACC_W-1:0]    fsum;
	logic signed [FILT_W-1:0]   filt_new;
	logic signed [ISUM_W-1:0]   isum;
	logic signed [INTEG_W-1:0]  integ_new;
	logic                       neg;
	logic [CMD_W-1:0]           mag;
	logic [DUTY_W-1:0]          mag_lim;

	pdpi_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.out_busy (out_valid_q & ~result.ready),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	pdpi_mac u_mac (
		.clk    (clk),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.acc_op (ctrl.acc_op),
		.acc    (acc)
	);

	assign sample.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_kp_q       <= RST_ANGLE_KP;
			angle_kd_q       <= RST_ANGLE_KD;
			speed_kp_q       <= RST_SPEED_KP;
			speed_ki_q       <= RST_SPEED_KI;
			angle_setpoint_q <= RST_SETPOINT;
			duty_limit_q     <= RST_DUTY_LIMIT;
			window_low_q     <= RST_WINDOW_LOW;
			window_high_q    <= RST_WINDOW_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_KP:    angle_kp_q       <= cfg_data[GAIN_W-1:0];
				REG_ANGLE_KD:    angle_kd_q       <= cfg_data[GAIN_W-1:0];
				REG_SPEED_KP:    speed_kp_q       <= cfg_data[GAIN_W-1:0];
				REG_SPEED_KI:    speed_ki_q       <= cfg_data[GAIN_W-1:0];
				REG_SETPOINT:    angle_setpoint_q <= cfg_data[SAMPLE_W-1:0];
				REG_DUTY_LIMIT:  duty_limit_q     <= cfg_data[DUTY_W-1:0];
				REG_WINDOW_LOW:  window_low_q     <= cfg_data[SAMPLE_W-1:0];
				REG_WINDOW_HIGH: window_high_q    <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	assign err_new = $signed({1'b0, sample.angle_sample}) - $signed({1'b0, angle_setpoint_q});
	assign derr    = DERR_W'(err_q) - DERR_W'(prev_q);

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			err_q <= err_new;
			enc_q <= sample.encoder_count;
			tgt_q <= sample.target_speed;
			cut_q <= (sample.angle_sample < window_low_q) ||
				(sample.angle_sample > window_high_q);
		end
		if (ctrl.pd_ld) begin
			pd_q <= PD_W'(trunc_shr_f(acc));
		end
		if (ctrl.cmd_ld) begin
			cmd_q <= CMD_W'(trunc_shr_2f(acc)) + CMD_W'(pd_q);
		end
	end

	always_comb begin
		case (ctrl.mul_sel)
			MS_KP_ERR: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed({1'b0, angle_kp_q});
			end
			MS_KD_DERR: begin
				mul_a = MUL_A_W'(derr);
				mul_b = $signed({1'b0, angle_kd_q});
			end
			MS_FILT_OLD: begin
				mul_a = MUL_A_W'(filt_q);
				mul_b = MUL_B_W'(FILT_OLD);
			end
			MS_ENC_NEW: begin
				mul_a = MUL_A_W'(enc_q);
				mul_b = MUL_B_W'(FILT_NEW_Q);
			end
			MS_FILT_SKP: begin
				mul_a = MUL_A_W'(filt_q);
				mul_b = $signed({1'b0, speed_kp_q});
			end
			MS_INTEG_SKI: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = $signed({1'b0, speed_ki_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// filter saturate, then integral clamp
	always_comb begin
		fsum = trunc_shr_f(acc);
		if (fsum > FILT_MAX_A) begin
			filt_new = FILT_W'(FILT_MAX_A);
		end else if (fsum < FILT_MIN_A) begin
			filt_new = FILT_W'(FILT_MIN_A);
		end else begin
			filt_new = FILT_W'(fsum);
		end
		isum = ISUM_W'(integ_q) + ISUM_W'(filt_q) - (ISUM_W'(tgt_q) <<< FRAC_BITS);
		if (isum > INTEG_MAX_S) begin
			integ_new = INTEG_W'(INTEG_MAX_S);
		end else if (isum < INTEG_MIN_S) begin
			integ_new = INTEG_W'(INTEG_MIN_S);
		end else begin
			integ_new = INTEG_W'(isum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			filt_q  <= '0;
			integ_q <= '0;
		end else begin
			if (ctrl.prev_ld) begin
				prev_q <= err_q;
			end
			if (ctrl.filt_ld) begin
				filt_q <= filt_new;
			end
			if (ctrl.integ_ld) begin
				integ_q <= integ_new;
			end
		end
	end

	assign neg     = cmd_q[CMD_W-1];
	assign mag     = neg ? CMD_W'(-cmd_q) : CMD_W'(cmd_q);
	assign mag_lim = (mag > CMD_W'(duty_limit_q)) ? duty_limit_q : mag[DUTY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_ld) begin
			duty_q    <= cut_q ? '0 : mag_lim;
			neg_q     <= neg;
			cut_out_q <= cut_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.duty           = duty_q;
	assign result.drive_negative = neg_q;
	assign result.cut_off        = cut_out_q;

endmodule

// ----- hdl/pdpi_checker.sv -----
// Port-level assertion checker for the pendulum controller, with its bind.
`timescale 1ns / 1ps
`include "pendulum_pd_pi_motor_controller_unit_defines.svh"
module pdpi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pdpi_pkg::DUTY_W-1:0]   duty,
	input logic                          drive_negative,
	input logic                          cut_off
);
	import pdpi_pkg::*;

	`PDPI_ASSERT_IMP(a_cut_zero_duty, out_valid && cut_off, duty == '0, "duty nonzero while cut off")
	`PDPI_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready held after a tick was taken")
	`PDPI_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(!in_ready), "result appeared without work")
	`PDPI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty) && $stable(drive_negative) && $stable(cut_off), "stalled result beat changed")

endmodule

bind pendulum_pd_pi_motor_controller_unit pdpi_checker u_pdpi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample.valid),
	.in_ready       (sample.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.duty           (result.duty),
	.drive_negative (result.drive_negative),
	.cut_off        (result.cut_off)
);

// ----- test/pendulum_pd_pi_motor_controller_unit_tb.sv -----
// Self-checking testbench of the pendulum PD/PI motor controller: random ticks, settings, stalls.
`timescale 1ns / 1ps
module pendulum_pd_pi_motor_controller_unit_tb;
	import pdpi_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam longint Q_ONE = 64'sd1 <<< FRAC_BITS;
	localparam longint FLT_HI = (64'sd1 <<< 23) - 1;
	localparam longint FLT_LO = -(64'sd1 <<< 23);
	localparam longint INTEG_CAP = 64'sd500 * Q_ONE;

	typedef struct packed {
		logic [SAMPLE_W-1:0] angle;
		logic [ENC_W-1:0]    enc;
		logic [TGT_W-1:0]    tgt;
	} tick_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              neg;
		logic              cut;
	} duty_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pdpi_in_if sample_if();
	pdpi_out_if result_if();

	pendulum_pd_pi_motor_controller_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_if),
		.result    (result_if)
	);

	// settings as the block holds them
	logic [GAIN_W-1:0]   kp_angle, kd_angle, kp_speed, ki_speed;
	logic [SAMPLE_W-1:0] set_angle, win_lo, win_hi;
	logic [DUTY_W-1:0]   duty_cap;

	// controller state
	logic signed [ERR_W-1:0] last_err;
	logic signed [23:0]      filt_acc;
	logic signed [17:0]      integ_acc;

	tick_t        tick_q[$];
	duty_result_t duty_expect_q[$];
	tick_t        drv_tick, acc_tick;
	duty_result_t seen, want;

	int idle_pct, stall_pct;
	int gap_left, stall_left;
	int fault_count = 0;
	int cycle_count = 0;

	function automatic duty_result_t predict_motor_command(input tick_t t);
		longint err, derr, pd_sum, pd_term, f, integ, pi_sum, pi_term, cmd, mag;
		duty_result_t r;
		err = longint'(t.angle) - longint'(set_angle);
		derr = err - longint'(last_err);
		pd_sum = longint'(kp_angle) * err + longint'(kd_angle) * derr;
		pd_term = (-pd_sum) / Q_ONE;
		last_err = err[ERR_W-1:0];

		f = (longint'(filt_acc) * 205 + longint'($signed(t.enc)) * Q_ONE * 51) / 256;
		if (f > FLT_HI) f = FLT_HI;
		if (f < FLT_LO) f = FLT_LO;
		filt_acc = f[23:0];
		integ = longint'(integ_acc) + f - longint'($signed(t.tgt)) * Q_ONE;
		if (integ > INTEG_CAP) integ = INTEG_CAP;
		if (integ < -INTEG_CAP) integ = -INTEG_CAP;
		integ_acc = integ[17:0];
		pi_sum = f * longint'(kp_speed) + integ * longint'(ki_speed);
		pi_term = pi_sum / (Q_ONE * Q_ONE);

		cmd = pi_term - pd_term;
		r.neg = cmd < 0;
		mag = r.neg ? -cmd : cmd;
		if (mag > longint'(duty_cap)) mag = longint'(duty_cap);
		r.cut = (t.angle < win_lo) || (t.angle > win_hi);
		if (r.cut) mag = 0;
		r.duty = mag[DUTY_W-1:0];
		return r;
	endfunction

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ANGLE_KP: kp_angle = data;
			REG_ANGLE_KD: kd_angle = data;
			REG_SPEED_KP: kp_speed = data;
			REG_SPEED_KI: ki_speed = data;
			REG_SETPOINT: set_angle = data[SAMPLE_W-1:0];
			REG_DUTY_LIMIT: duty_cap = data[DUTY_W-1:0];
			REG_WINDOW_LOW: win_lo = data[SAMPLE_W-1:0];
			REG_WINDOW_HIGH: win_hi = data[SAMPLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_settings(input logic [15:0] akp, akd, skp, ski, sp, dl, wl, wh);
		write_register(REG_ANGLE_KP, akp);
		write_register(REG_ANGLE_KD, akd);
		write_register(REG_SPEED_KP, skp);
		write_register(REG_SPEED_KI, ski);
		write_register(REG_SETPOINT, sp);
		write_register(REG_DUTY_LIMIT, dl);
		write_register(REG_WINDOW_LOW, wl);
		write_register(REG_WINDOW_HIGH, wh);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_settings();
		logic [15:0] gain [4];
		logic [DUTY_W-1:0] dl;
		int sp, r, lo, hi;
		for (int i = 0; i < 4; i++) begin
			gain[i] = 16'($urandom());
			if ($urandom_range(0, 2) != 0) gain[i] = gain[i] >> $urandom_range(0, 10);
			if ($urandom_range(0, 7) == 0) gain[i] = '0;
		end
		sp = $urandom_range(0, 4095);
		r = $urandom_range(0, 1200);
		lo = (sp - r < 0) ? 0 : sp - r;
		hi = (sp + r > 4095) ? 4095 : sp + r;
		if ($urandom_range(0, 4) == 0) begin
			lo = $urandom_range(0, 4095);
			hi = $urandom_range(0, 4095);
		end
		case ($urandom_range(0, 5))
			0: dl = '0;
			1: dl = '1;
			default: dl = DUTY_W'($urandom_range(0, 8191));
		endcase
		write_settings(gain[0], gain[1], gain[2], gain[3], {4'($urandom()), 12'(sp)},
			{3'($urandom()), dl}, {4'($urandom()), 12'(lo)}, {4'($urandom()), 12'(hi)});
	endtask

	task automatic pick_idle(input bit allow);
		case ($urandom_range(0, 3))
			0: idle_pct = 0;
			1: idle_pct = 5;
			2: idle_pct = 25;
			default: idle_pct = 50;
		endcase
		case ($urandom_range(0, 3))
			0: stall_pct = 0;
			1: stall_pct = 5;
			2: stall_pct = 25;
			default: stall_pct = 50;
		endcase
		if (!allow) begin
			idle_pct = 0;
			stall_pct = 0;
		end
	endtask

	task automatic queue_tick(input int angle, input int enc, input int tgt);
		tick_t t;
		t.angle = angle[SAMPLE_W-1:0];
		t.enc = enc[ENC_W-1:0];
		t.tgt = tgt[TGT_W-1:0];
		tick_q.push_back(t);
	endtask

	// Segments of correlated encoder counts drive the filter and integrator to their limits.
	task automatic queue_random_ticks(input int count);
		int left, seg, mode, enc_base, enc_span, tgt_fixed, a, e, g, pick;
		bit tgt_hold;
		left = count;
		while (left > 0) begin
			seg = $urandom_range(4, 40);
			mode = $urandom_range(0, 9);
			enc_span = 1 << $urandom_range(2, 14);
			enc_base = int'($urandom_range(0, 2 * enc_span)) - enc_span;
			tgt_hold = $urandom_range(0, 1);
			tgt_fixed = int'($urandom_range(0, 255)) - 128;
			for (int k = 0; k < seg && left > 0; k++) begin
				case (mode)
					0, 1: e = int'($urandom_range(0, 65535)) - 32768;
					2: e = 32767 - int'($urandom_range(0, 2000));
					3: e = -32768 + int'($urandom_range(0, 2000));
					default: e = enc_base + int'($urandom_range(0, 128)) - 64;
				endcase
				if (e > 32767) e = 32767;
				if (e < -32768) e = -32768;
				pick = $urandom_range(0, 9);
				if (pick < 7)
					a = int'(set_angle) + int'($urandom_range(0, 400)) - 200;
				else if (pick < 8)
					a = ($urandom_range(0, 1) ? int'(win_lo) : int'(win_hi))
						+ int'($urandom_range(0, 2)) - 1;
				else
					a = $urandom_range(0, 4095);
				if (a < 0) a = 0;
				if (a > 4095) a = 4095;
				g = tgt_hold ? tgt_fixed : int'($urandom_range(0, 255)) - 128;
				queue_tick(a, e, g);
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		while (!(tick_q.size() == 0 && !sample_if.valid && duty_expect_q.size() == 0))
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			sample_if.angle_sample <= '0;
			sample_if.encoder_count <= '0;
			sample_if.target_speed <= '0;
			gap_left <= 0;
		end else begin
			if (sample_if.valid && sample_if.ready) begin
				acc_tick.angle = sample_if.angle_sample;
				acc_tick.enc = sample_if.encoder_count;
				acc_tick.tgt = sample_if.target_speed;
				duty_expect_q.push_back(predict_motor_command(acc_tick));
			end
			if (!sample_if.valid || sample_if.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					sample_if.valid <= 1'b0;
				end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
					gap_left <= $urandom_range(0, 13);
					sample_if.valid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					drv_tick = tick_q.pop_front();
					sample_if.angle_sample <= drv_tick.angle;
					sample_if.encoder_count <= drv_tick.enc;
					sample_if.target_speed <= drv_tick.tgt;
					sample_if.valid <= 1'b1;
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				seen.duty = result_if.duty;
				seen.neg = result_if.drive_negative;
				seen.cut = result_if.cut_off;
				if (duty_expect_q.size() == 0) begin
					fault_count = fault_count + 1;
					if (fault_count <= 10)
						$display("%0t: result beat with none expected: duty %0d neg %0b cut %0b",
							$time, seen.duty, seen.neg, seen.cut);
				end else begin
					want = duty_expect_q.pop_front();
					if (seen.duty !== want.duty || seen.neg !== want.neg
							|| seen.cut !== want.cut) begin
						fault_count = fault_count + 1;
						if (fault_count <= 10)
							$display("%0t: mismatch: expected duty %0d neg %0b cut %0b, got duty %0d neg %0b cut %0b",
								$time, want.duty, want.neg, want.cut, seen.duty, seen.neg, seen.cut);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_if.ready <= 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left <= $urandom_range(0, 13);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		kp_angle = RST_ANGLE_KP;
		kd_angle = RST_ANGLE_KD;
		kp_speed = RST_SPEED_KP;
		ki_speed = RST_SPEED_KI;
		set_angle = RST_SETPOINT;
		duty_cap = RST_DUTY_LIMIT;
		win_lo = RST_WINDOW_LOW;
		win_hi = RST_WINDOW_HIGH;
		last_err = '0;
		filt_acc = '0;
		integ_acc = '0;
		idle_pct = 20;
		stall_pct = 20;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window edges, field extremes, integrator pinned both ways
		queue_tick(3270, 0, 0);
		queue_tick(3270, 0, 0);
		queue_tick(0, -32768, -128);
		queue_tick(4095, 32767, 127);
		queue_tick(2899, 1, 1);
		queue_tick(2900, -1, -1);
		queue_tick(3600, 256, 0);
		queue_tick(3601, -256, 0);
		repeat (7) queue_tick(3300, 32767, -128);
		repeat (6) queue_tick(3240, -32768, 127);
		queue_tick(3270, 0, 0);
		wait_drained();

		// all gains at full scale, open window
		write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2048, 16'h1FFF,
			16'd0, 16'hFFFF);
		pick_idle(1'b1);
		queue_tick(0, 32767, 127);
		queue_tick(4095, -32768, -128);
		queue_tick(2048, 0, 0);
		queue_random_ticks(150);
		wait_drained();

		// inverted window, zero duty limit, direction from speed path only
		write_settings(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hE000,
			16'h0FFF, 16'h0000);
		pick_idle(1'b1);
		queue_tick(3270, 32767, 0);
		queue_tick(3270, -32768, 0);
		queue_random_ticks(60);
		wait_drained();

		repeat (6) begin
			random_settings();
			pick_idle(1'b1);
			queue_random_ticks(150);
			wait_drained();
		end

		write_settings(RST_ANGLE_KP, RST_ANGLE_KD, RST_SPEED_KP, RST_SPEED_KI,
			16'(RST_SETPOINT), 16'(RST_DUTY_LIMIT), 16'(RST_WINDOW_LOW), 16'(RST_WINDOW_HIGH));
		pick_idle(1'b0);
		queue_random_ticks(290);
		wait_drained();
		repeat (40) @(posedge clk);

		if (fault_count == 0 && duty_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/pdpi_pkg.sv
hdl/pdpi_ifs.sv
hdl/pdpi_mac.sv
hdl/pdpi_seq.sv
hdl/pendulum_pd_pi_motor_controller_unit.sv
hdl/pdpi_checker.sv
test/pendulum_pd_pi_motor_controller_unit_tb.sv
